### src/fba_pkg.sv
// Shared types, codes and helper functions of the frame bitmap allocator.
package fba_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_MARK    = 2'd2;
    localparam logic [1:0] ACT_RESERVE = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;
    localparam logic [1:0] ST_NOCHG   = 2'd3;

    typedef struct packed {
        logic idle;
        logic clear_wr;
        logic load;
        logic check;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic clear_last;
        logic walk_done;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {1'b0, n};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] n);
        return (c >= n) ? (c - n) : '0;
    endfunction

endpackage

### src/fba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fba_ctrl.sv
// Controller state machine of the frame bitmap allocator.
module fba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fba_pkg::t_sts i_sts,
    output fba_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.early ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.walk_done ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/fba_dp.sv
// Datapath of the frame bitmap allocator: bitmap store, counters and result register.
module fba_dp #(
    parameter int NUM_FRAMES    = 65536,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fba_pkg::t_cmd              i_cmd,
    output fba_pkg::t_sts              o_sts,
    input  logic [1:0]                 i_action,
    input  logic [31:0]                i_byte_address,
    input  logic [32:0]                i_region_bytes,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [31:0]                o_frame_address,
    output logic [1:0]                 o_status,
    output logic [fba_pkg::CNT_W-1:0]  o_total_frames,
    output logic [fba_pkg::CNT_W-1:0]  o_free_frames,
    output logic [fba_pkg::CNT_W-1:0]  o_used_frames
);

    localparam int MW  = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW  = (MW > 1) ? $clog2(MW) : 1;
    localparam int SH  = $clog2(FRAME_BYTES);
    localparam int WSH = $clog2(MAP_WORD_BITS);
    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int EW  = FW + WSH;
    localparam int XW  = AW + WSH;
    localparam int CW  = fba_pkg::CNT_W;
    localparam logic [MAP_WORD_BITS-1:0] ALL = '1;

    logic [1:0]               r_act;
    logic [1:0]               r_status;
    logic [31:0]              r_fa;
    logic                     r_changed;
    logic                     r_past;
    logic [FW-1:0]            r_frame;
    logic [AW-1:0]            r_lo_w;
    logic [WSH-1:0]           r_lo_b;
    logic [AW-1:0]            r_hi_w;
    logic [WSH-1:0]           r_hi_b;
    logic [AW-1:0]            r_word;
    logic [AW-1:0]            r_hint;
    logic                     r_none;
    logic [AW-1:0]            r_clr;
    logic [CW-1:0]            r_total;
    logic [CW-1:0]            r_free;
    logic [CW-1:0]            r_used;
    logic                     r_ovalid;
    logic [31:0]              r_ofa;
    logic [1:0]               r_ost;
    logic [CW-1:0]            r_otot;
    logic [CW-1:0]            r_ofree;
    logic [CW-1:0]            r_oused;

    logic [1:0]               n_status;
    logic [31:0]              n_fa;
    logic                     n_changed;
    logic [AW-1:0]            n_word;
    logic [AW-1:0]            n_hint;
    logic                     n_none;
    logic [CW-1:0]            n_total;
    logic [CW-1:0]            n_free;
    logic [CW-1:0]            n_used;

    logic [33:0]              f34;
    logic [33:0]              end34;
    logic [33:0]              last34;
    logic                     first_beyond;
    logic                     past;
    logic [FW-1:0]            first_f;
    logic [FW-1:0]            hi_f;
    logic [EW-1:0]            first_e;
    logic [EW-1:0]            hi_e;

    logic [MAP_WORD_BITS-1:0] rd;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic [MAP_WORD_BITS-1:0] n_wdata;
    logic                     n_we;
    logic [MAP_WORD_BITS-1:0] lo_mask;
    logic [MAP_WORD_BITS-1:0] hi_mask;
    logic [MAP_WORD_BITS-1:0] mask;
    logic [MAP_WORD_BITS-1:0] chg;
    logic [CW-1:0]            nchg;
    logic                     full;
    logic [WSH-1:0]           idx;
    logic [XW-1:0]            fidx;
    logic                     last_word;
    logic                     free_hit;
    logic                     lower;
    logic                     sts_early;
    logic                     sts_walk_done;

    assign f34          = {2'b0, i_byte_address} >> SH;
    assign end34        = {2'b0, i_byte_address} + {1'b0, i_region_bytes} - 34'd1;
    assign last34       = end34 >> SH;
    assign first_beyond = f34 >= 34'(NUM_FRAMES);
    assign past         = last34 >= 34'(NUM_FRAMES);
    assign first_f      = FW'(f34);
    assign hi_f         = past ? FW'(NUM_FRAMES - 1) : FW'(last34);
    assign first_e      = EW'(first_f);
    assign hi_e         = EW'(hi_f);

    always_comb begin
        sts_early = 1'b0;
        case (i_action)
            fba_pkg::ACT_ALLOC: sts_early = r_none;
            fba_pkg::ACT_FREE:  sts_early = first_beyond;
            default:            sts_early = (i_region_bytes == '0) || first_beyond;
        endcase
    end

    assign o_sts = '{early: sts_early,
                     clear_last: (r_clr == AW'(MW - 1)),
                     walk_done: sts_walk_done,
                     out_free: (!r_ovalid || !i_stall)};

    fba_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(MW)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_word),
        .o_rdata(rd)
    );

    assign we    = i_cmd.clear_wr || (i_cmd.check && n_we);
    assign waddr = i_cmd.clear_wr ? r_clr : r_word;
    assign wdata = i_cmd.clear_wr ? ALL : n_wdata;

    always_comb begin
        lo_mask = (r_word == r_lo_w) ? (ALL << r_lo_b) : ALL;
        hi_mask = (r_word == r_hi_w) ? (ALL >> (WSH'(MAP_WORD_BITS - 1) - r_hi_b)) : ALL;
        mask    = lo_mask & hi_mask;
        if (r_act == fba_pkg::ACT_MARK && r_word == '0) begin
            mask[0] = 1'b0;
        end
        chg  = (r_act == fba_pkg::ACT_MARK) ? (rd & mask) : (~rd & mask);
        nchg = CW'($countones(chg));
        full = rd == ALL;
        idx  = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
            if (!rd[j]) begin
                idx = WSH'(j);
            end
        end
        fidx      = (XW'(r_word) << WSH) | XW'(idx);
        last_word = r_word == AW'(MW - 1);
        free_hit  = rd[r_lo_b] && (r_frame != '0);
    end

    always_comb begin
        n_status  = r_status;
        n_fa      = r_fa;
        n_changed = r_changed;
        n_word    = r_word;
        n_hint    = r_hint;
        n_none    = r_none;
        n_total   = r_total;
        n_free    = r_free;
        n_used    = r_used;
        n_we      = 1'b0;
        n_wdata   = rd;
        lower     = 1'b0;
        sts_walk_done = 1'b1;
        if (i_cmd.load) begin
            n_fa      = '0;
            n_changed = 1'b0;
            n_word    = AW'(first_e >> WSH);
            case (i_action)
                fba_pkg::ACT_ALLOC: begin
                    n_status = fba_pkg::ST_NOFREE;
                    n_word   = r_hint;
                end
                fba_pkg::ACT_FREE: begin
                    n_status = fba_pkg::ST_BEYOND;
                end
                default: begin
                    n_status = (i_region_bytes == '0) ? fba_pkg::ST_NOCHG
                                                      : fba_pkg::ST_BEYOND;
                end
            endcase
        end else if (i_cmd.check) begin
            case (r_act)
                fba_pkg::ACT_ALLOC: begin
                    sts_walk_done = !full || last_word;
                    if (!full) begin
                        n_we     = 1'b1;
                        n_wdata  = rd | (MAP_WORD_BITS'(1) << idx);
                        n_used   = fba_pkg::sat_add(r_used, CW'(1));
                        n_free   = fba_pkg::sat_sub(r_free, CW'(1));
                        n_fa     = 32'(64'(fidx) << SH);
                        n_status = fba_pkg::ST_DONE;
                        n_hint   = r_word;
                    end else if (last_word) begin
                        n_status = fba_pkg::ST_NOFREE;
                        n_none   = 1'b1;
                    end else begin
                        n_word = r_word + AW'(1);
                    end
                end
                fba_pkg::ACT_FREE: begin
                    if (free_hit) begin
                        n_we      = 1'b1;
                        n_wdata   = rd & ~(MAP_WORD_BITS'(1) << r_lo_b);
                        n_used    = fba_pkg::sat_sub(r_used, CW'(1));
                        n_free    = fba_pkg::sat_add(r_free, CW'(1));
                        n_status  = fba_pkg::ST_DONE;
                        lower     = 1'b1;
                    end else begin
                        n_status = fba_pkg::ST_NOCHG;
                    end
                end
                default: begin
                    sts_walk_done = r_word == r_hi_w;
                    n_we          = chg != '0;
                    n_changed     = r_changed || (chg != '0);
                    if (r_act == fba_pkg::ACT_MARK) begin
                        n_wdata = rd & ~mask;
                        n_free  = fba_pkg::sat_add(r_free, nchg);
                        n_total = fba_pkg::sat_add(r_total, nchg);
                        lower   = chg != '0;
                    end else begin
                        n_wdata = rd | mask;
                        n_free  = fba_pkg::sat_sub(r_free, nchg);
                        n_total = fba_pkg::sat_sub(r_total, nchg);
                    end
                    if (r_past) begin
                        n_status = fba_pkg::ST_BEYOND;
                    end else begin
                        n_status = n_changed ? fba_pkg::ST_DONE : fba_pkg::ST_NOCHG;
                    end
                    if (r_word != r_hi_w) begin
                        n_word = r_word + AW'(1);
                    end
                end
            endcase
            if (lower && (r_none || r_word < r_hint)) begin
                n_hint = r_word;
                n_none = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_hint   <= '0;
            r_none   <= 1'b1;
            r_total  <= '0;
            r_free   <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_word   <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            r_hint  <= n_hint;
            r_none  <= n_none;
            r_total <= n_total;
            r_free  <= n_free;
            r_used  <= n_used;
            r_word  <= n_word;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_fa      <= n_fa;
        r_changed <= n_changed;
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_past  <= past;
            r_frame <= first_f;
            r_lo_w  <= AW'(first_e >> WSH);
            r_lo_b  <= WSH'(first_f);
            r_hi_w  <= AW'(hi_e >> WSH);
            r_hi_b  <= WSH'(hi_f);
        end
        if (i_cmd.out_load) begin
            r_ofa   <= r_fa;
            r_ost   <= r_status;
            r_otot  <= r_total;
            r_ofree <= r_free;
            r_oused <= r_used;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_frame_address = r_ofa;
    assign o_status        = r_ost;
    assign o_total_frames  = r_otot;
    assign o_free_frames   = r_ofree;
    assign o_used_frames   = r_oused;

endmodule

### src/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator.
// After reset the block writes every bitmap word to all ones, one word a cycle, and it
// takes no item until that clear is done. Each item then gives one result, which is
// registered once the item's work ends and no earlier result is stalled, and the block
// takes no new item before it has loaded that result. A free reads the frame's bitmap
// word and writes it back when the frame is marked used and is not frame 0. An allocation
// reads the bitmap memory from the lowest word that may hold a free frame, one word after
// another, until a word has a free frame or the last word is read. A region action reads
// each bitmap word it covers in turn and writes back those it changes. Every word visit
// is a read of the single bitmap memory and a possible write back; an item with an early
// answer skips the bitmap. A stalled result holds off the next result until the stall ends.
module frame_bitmap_allocator #(
    parameter int NUM_FRAMES    = 65536,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_action,
    input  logic [31:0]               i_byte_address,
    input  logic [32:0]               i_region_bytes,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [31:0]               o_frame_address,
    output logic [1:0]                o_status,
    output logic [fba_pkg::CNT_W-1:0] o_total_frames,
    output logic [fba_pkg::CNT_W-1:0] o_free_frames,
    output logic [fba_pkg::CNT_W-1:0] o_used_frames
);

    fba_pkg::t_cmd cmd;
    fba_pkg::t_sts sts;

    fba_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    fba_dp #(
        .NUM_FRAMES   (NUM_FRAMES),
        .FRAME_BYTES  (FRAME_BYTES),
        .MAP_WORD_BITS(MAP_WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_byte_address (i_byte_address),
        .i_region_bytes (i_region_bytes),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_frame_address(o_frame_address),
        .o_status       (o_status),
        .o_total_frames (o_total_frames),
        .o_free_frames  (o_free_frames),
        .o_used_frames  (o_used_frames)
    );

    assign o_stall = !cmd.idle;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took a second item while the first was in work");

    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fba_pkg::ST_NOFREE) |-> (o_frame_address == '0))
        else $error("failed allocation returned a nonzero address");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_valid)
        else $error("finished result was not presented");

endmodule
